[src/tea_pkg.sv]
// shared types, constants and the round mixing function of the tea cipher
`default_nettype none
package tea_pkg;

   localparam int ROUNDS_DEFAULT = 32;
   localparam int BLOCK_W        = 64;
   localparam int WORD_W         = 32;
   localparam int KEY_WORDS      = 4;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 32;

   localparam logic [WORD_W-1:0] DELTA = 32'h9E3779B9;

   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      KEY_WORD_0 = 2'd0,
      KEY_WORD_1 = 2'd1,
      KEY_WORD_2 = 2'd2,
      KEY_WORD_3 = 2'd3
   } key_index_type;

   typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_type;

   typedef struct packed {
      logic              mode;
      logic [WORD_W-1:0] v0;
      logic [WORD_W-1:0] v1;
      logic              last;
   } stage_word_type;

   function automatic logic [WORD_W-1:0] tea_mix(
      input logic [WORD_W-1:0] x,
      input logic [WORD_W-1:0] sum,
      input logic [WORD_W-1:0] ka,
      input logic [WORD_W-1:0] kb
   );
      return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
   endfunction

endpackage
`default_nettype wire

[src/tea_ifs.sv]
// request and response channel interfaces of the tea cipher
`default_nettype none
interface tea_req_if;
   import tea_pkg::*;
   logic               valid;
   logic               ready;
   logic               mode;
   logic [BLOCK_W-1:0] block_in;
   logic               last_in;

   modport source (output valid, output mode, output block_in, output last_in, input ready);
   modport sink   (input valid, input mode, input block_in, input last_in, output ready);
endinterface

interface tea_rsp_if;
   import tea_pkg::*;
   logic               valid;
   logic               ready;
   logic [BLOCK_W-1:0] block_out;
   logic               last_out;

   modport source (output valid, output block_out, output last_out, input ready);
   modport sink   (input valid, input block_out, input last_out, output ready);
endinterface
`default_nettype wire

[src/tea_block_cipher.sv]
// top level of the pipelined tea block cipher
// usage:
//   req_chan carries one 64-bit block per word with a mode bit (0 encrypt,
//   1 decrypt) and a last flag; rsp_chan returns the transformed block and
//   the copied last flag, in the same order (ecb)
//   the key is four 32-bit words written on the csr port, index 0 to 3,
//   only while no word is in flight; the user must keep to this, the block does not enforce it
//   one register stage per half round lies between acceptance and rsp_chan.valid
//   throughput is one word per cycle unless the receiver stalls; every stage
//   holds its own valid bit and bubbles pass through like words
//   when the receiver stalls a valid result, the whole pipeline freezes and
//   req_chan.ready drops in the same cycle; nothing is lost or repeated
//   reset clears all valid bits and the key words to zero
`default_nettype none
module tea_block_cipher #(
   parameter int ROUNDS = tea_pkg::ROUNDS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   tea_req_if.sink                              req_chan,
   tea_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_write,
   input  wire logic [tea_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tea_pkg::CSR_DATA_W-1:0]  csr_data
);
   import tea_pkg::*;

   localparam int STAGES = 2 * ROUNDS;

   key_type        key;
   logic           enable;
   logic           stage_valid [0:STAGES];
   stage_word_type stage_data  [0:STAGES];

   tea_key_regs u_key_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .key       (key)
   );

   assign enable = !stage_valid[STAGES] || rsp_chan.ready;
   assign req_chan.ready = enable;

   assign stage_valid[0] = req_chan.valid;
   assign stage_data[0]  = {req_chan.mode, req_chan.block_in, req_chan.last_in};

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      tea_half_round #(
         .ROUNDS (ROUNDS),
         .HALF   (s)
      ) u_half_round (
         .clock      (clock),
         .reset      (reset),
         .enable     (enable),
         .prev_valid (stage_valid[s]),
         .prev_data  (stage_data[s]),
         .key        (key),
         .next_valid (stage_valid[s+1]),
         .next_data  (stage_data[s+1])
      );
   end

   assign rsp_chan.valid     = stage_valid[STAGES];
   assign rsp_chan.block_out = {stage_data[STAGES].v0, stage_data[STAGES].v1};
   assign rsp_chan.last_out  = stage_data[STAGES].last;
endmodule
`default_nettype wire

[src/tea_key_regs.sv]
// key word registers written through the csr port
`default_nettype none
module tea_key_regs (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write,
   input  wire logic [tea_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tea_pkg::CSR_DATA_W-1:0]  csr_data,
   output tea_pkg::key_type                     key
);
   import tea_pkg::*;

   key_type key_ff;
   key_type key_in;

   always_comb begin
      key_in = key_ff;
      if (csr_write) begin
         unique case (key_index_type'(csr_index))
            KEY_WORD_0: key_in[0] = csr_data[WORD_W-1:0];
            KEY_WORD_1: key_in[1] = csr_data[WORD_W-1:0];
            KEY_WORD_2: key_in[2] = csr_data[WORD_W-1:0];
            KEY_WORD_3: key_in[3] = csr_data[WORD_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign key = key_ff;
endmodule
`default_nettype wire

[src/tea_half_round.sv]
// one registered half round of tea, encrypt or decrypt per word
`default_nettype none
module tea_half_round #(
   parameter int ROUNDS = tea_pkg::ROUNDS_DEFAULT,
   parameter int HALF   = 0
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    enable,
   input  wire logic                    prev_valid,
   input  wire tea_pkg::stage_word_type prev_data,
   input  wire tea_pkg::key_type        key,
   output logic                         next_valid,
   output tea_pkg::stage_word_type      next_data
);
   import tea_pkg::*;

   localparam logic [WORD_W-1:0] SUM_ENC = WORD_W'(64'(DELTA) * 64'(HALF / 2 + 1));
   localparam logic [WORD_W-1:0] SUM_DEC = WORD_W'(64'(DELTA) * 64'(ROUNDS - HALF / 2));
   localparam bit FIRST_HALF = (HALF % 2) == 0;

   logic           valid_ff;
   stage_word_type data_ff;
   stage_word_type data_in;
   logic [WORD_W-1:0] sum;

   always_comb begin
      data_in = prev_data;
      sum = (prev_data.mode == MODE_DECRYPT) ? SUM_DEC : SUM_ENC;
      if (FIRST_HALF) begin
         if (prev_data.mode == MODE_DECRYPT) begin
            data_in.v1 = prev_data.v1 - tea_mix(prev_data.v0, sum, key[2], key[3]);
         end else begin
            data_in.v0 = prev_data.v0 + tea_mix(prev_data.v1, sum, key[0], key[1]);
         end
      end else begin
         if (prev_data.mode == MODE_DECRYPT) begin
            data_in.v0 = prev_data.v0 - tea_mix(prev_data.v1, sum, key[0], key[1]);
         end else begin
            data_in.v1 = prev_data.v1 + tea_mix(prev_data.v0, sum, key[2], key[3]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign next_valid = valid_ff;
   assign next_data  = data_ff;
endmodule
`default_nettype wire

[src/tea_checker.sv]
// port level checker of the tea cipher and its bind to the top level
`default_nettype none
module tea_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [tea_pkg::BLOCK_W-1:0] rsp_block_out,
   input wire logic                        rsp_last_out
);
   import tea_pkg::*;

   // stalled response word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_block_out) && $stable(rsp_last_out))
      else $error("tea: stalled response word changed");

   // reset empties the pipeline
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("tea: response valid after reset");

   // empty output or taken output lets a new word in
   assert property (@(posedge clock) !rsp_valid || rsp_ready |-> req_ready)
      else $error("tea: request blocked while output free");

   // a stalled output freezes the input side
   assert property (@(posedge clock) rsp_valid && !rsp_ready |-> !req_ready)
      else $error("tea: request taken while output stalled");
endmodule

bind tea_block_cipher tea_checker u_tea_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_block_out (rsp_chan.block_out),
   .rsp_last_out  (rsp_chan.last_out)
);
`default_nettype wire

[bench/tb_tea_block_cipher.sv]
// testbench for the tea block cipher: ecb words checked against an in-bench predictor
`timescale 1ns / 1ps
module tb_tea_block_cipher;
   import tea_pkg::*;

   localparam int                CIPHER_ROUNDS = 32;
   localparam logic [WORD_W-1:0] ROUND_STEP    = 32'h9E3779B9;
   localparam int                HOLD_CYCLES   = 400;
   localparam int                CYCLE_LIMIT   = 400000;
   localparam int                RANDOM_WORDS  = 345;

   typedef struct packed {
      logic [BLOCK_W-1:0] block;
      logic               last;
   } cipher_word_type;

   class cipher_scoreboard;
      logic [WORD_W-1:0] key_copy [KEY_WORDS];
      cipher_word_type   expected_words [$];
      int                error_count;

      function new();
         foreach (key_copy[i]) key_copy[i] = '0;
         error_count = 0;
      endfunction

      function void set_key(input key_index_type idx, input logic [WORD_W-1:0] value);
         key_copy[idx] = value;
      endfunction

      function logic [WORD_W-1:0] round_mix(input logic [WORD_W-1:0] x,
                                            input logic [WORD_W-1:0] sum,
                                            input logic [WORD_W-1:0] ka,
                                            input logic [WORD_W-1:0] kb);
         logic [WORD_W-1:0] shl, shr;
         shl = {x[WORD_W-5:0], 4'b0000};
         shr = {5'b00000, x[WORD_W-1:5]};
         return (shl + ka) ^ (x + sum) ^ (shr + kb);
      endfunction

      function logic [BLOCK_W-1:0] encipher(input logic [BLOCK_W-1:0] blk);
         logic [WORD_W-1:0] y, z, sum;
         y   = blk[BLOCK_W-1:WORD_W];
         z   = blk[WORD_W-1:0];
         sum = '0;
         for (int r = 0; r < CIPHER_ROUNDS; r++) begin
            sum = sum + ROUND_STEP;
            y   = y + round_mix(z, sum, key_copy[0], key_copy[1]);
            z   = z + round_mix(y, sum, key_copy[2], key_copy[3]);
         end
         return {y, z};
      endfunction

      function logic [BLOCK_W-1:0] decipher(input logic [BLOCK_W-1:0] blk);
         logic [WORD_W-1:0] y, z, sum;
         y   = blk[BLOCK_W-1:WORD_W];
         z   = blk[WORD_W-1:0];
         sum = '0;
         for (int r = 0; r < CIPHER_ROUNDS; r++) sum = sum + ROUND_STEP;
         for (int r = 0; r < CIPHER_ROUNDS; r++) begin
            z   = z - round_mix(y, sum, key_copy[2], key_copy[3]);
            y   = y - round_mix(z, sum, key_copy[0], key_copy[1]);
            sum = sum - ROUND_STEP;
         end
         return {y, z};
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      task report_mismatch(input string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         error_count++;
      endtask

      task note_word(input logic mode, input logic [BLOCK_W-1:0] blk, input logic last);
         cipher_word_type w;
         w.block = (mode == MODE_DECRYPT) ? decipher(blk) : encipher(blk);
         w.last  = last;
         expected_words.push_back(w);
      endtask

      task check_word(input logic [BLOCK_W-1:0] blk, input logic last);
         cipher_word_type w;
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h last %b", blk, last));
            return;
         end
         w = expected_words.pop_front();
         if (blk !== w.block)
            report_mismatch($sformatf("block_out %h, expected %h", blk, w.block));
         if (last !== w.last)
            report_mismatch($sformatf("last_out %b, expected %b", last, w.last));
      endtask
   endclass

   logic clock;
   logic reset;
   logic csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   int send_idle_pct;
   int recv_idle_pct;
   bit rsp_hold;
   int cycle_count;

   cipher_scoreboard sb;

   tea_req_if req_chan ();
   tea_rsp_if rsp_chan ();

   tea_block_cipher dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_chan.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_word(rsp_chan.block_out, rsp_chan.last_out);
   end

   task csr_word(input key_index_type idx, input logic [WORD_W-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      sb.set_key(idx, value);
      @(negedge clock);
   endtask

   task write_keys(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                   input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
      csr_word(KEY_WORD_0, k0);
      csr_word(KEY_WORD_1, k1);
      csr_word(KEY_WORD_2, k2);
      csr_word(KEY_WORD_3, k3);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task send_word(input logic mode, input logic [BLOCK_W-1:0] blk, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.mode     <= mode;
      req_chan.block_in <= blk;
      req_chan.last_in  <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sb.note_word(mode, blk, last);
      @(negedge clock);
   endtask

   task end_burst();
      req_chan.valid <= 1'b0;
      @(negedge clock);
   endtask

   task drain();
      while (sb.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task send_directed();
      logic [BLOCK_W-1:0] sample;
      sample = 64'h0123456789ABCDEF;
      send_word(MODE_ENCRYPT, '0, 1'b0);
      send_word(MODE_ENCRYPT, '1, 1'b1);
      send_word(MODE_DECRYPT, '0, 1'b1);
      send_word(MODE_DECRYPT, '1, 1'b0);
      send_word(MODE_ENCRYPT, sample, 1'b0);
      send_word(MODE_DECRYPT, sb.encipher(sample), 1'b1);
      send_word(MODE_ENCRYPT, 64'h8000000000000000, 1'b1);
      send_word(MODE_ENCRYPT, 64'h0000000000000001, 1'b1);
      send_word(MODE_DECRYPT, 64'h0000000180000000, 1'b0);
      send_word(MODE_ENCRYPT, 64'hFFFFFFFF00000000, 1'b0);
      send_word(MODE_DECRYPT, 64'h00000000FFFFFFFF, 1'b1);
      end_burst();
   endtask

   function automatic logic [BLOCK_W-1:0] pick_block();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return 64'd1 << $urandom_range(BLOCK_W - 1);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task send_random(input int count);
      logic [BLOCK_W-1:0] blk;
      logic [BLOCK_W-1:0] cipher;
      bit                 have_cipher;
      int                 pick;
      have_cipher = 0;
      cipher      = '0;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(9);
         if (pick < 4) begin
            blk         = pick_block();
            cipher      = sb.encipher(blk);
            have_cipher = 1;
            send_word(MODE_ENCRYPT, blk, $urandom_range(3) == 0);
         end else if (pick < 7 && have_cipher) begin
            // round trip back to the plaintext
            send_word(MODE_DECRYPT, cipher, $urandom_range(3) == 0);
         end else begin
            send_word(MODE_DECRYPT, pick_block(), $urandom_range(3) == 0);
         end
      end
      end_burst();
   endtask

   initial begin
      sb                = new();
      cycle_count       = 0;
      rsp_hold          = 0;
      send_idle_pct     = 0;
      recv_idle_pct     = 0;
      reset             = 1'b1;
      csr_write         = 1'b0;
      csr_index         = '0;
      csr_data          = '0;
      req_chan.valid    = 1'b0;
      req_chan.mode     = MODE_ENCRYPT;
      req_chan.block_in = '0;
      req_chan.last_in  = 1'b0;
      rsp_chan.ready    = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset key of all zeros, then all ones
      send_directed();
      drain();
      write_keys('1, '1, '1, '1);
      send_directed();
      drain();

      write_keys($urandom, $urandom, $urandom, $urandom);
      send_idle_pct = 21;
      recv_idle_pct = 82;
      send_random(RANDOM_WORDS);
      drain();

      write_keys(32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFF, 32'h00000000);
      send_idle_pct = 82;
      recv_idle_pct = 21;
      send_random(RANDOM_WORDS);
      drain();

      write_keys($urandom, $urandom, $urandom, $urandom);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      // long receiver stall so the pipeline fills and drops ready
      fork
         begin
            @(posedge clock);
            rsp_hold = 1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 0;
         end
      join_none
      send_random(RANDOM_WORDS);

      while (sb.pending() != 0) @(posedge clock);
      repeat (2 * CIPHER_ROUNDS + 16) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
